>>> rtl/eulr_pkg.sv
// eulr_pkg: shared constants for the euler pivot rotation block
// register indexes, angle constants, cordic gain, cordic arctangent table; no dependencies
package eulr_pkg;
	localparam int AngleW = 15;
	localparam int CordicSteps = 20;
	localparam int CordicW = 34;
	localparam int ZW = 22;

	typedef enum logic [2:0] {
		REG_PIVOT_X = 3'd0,
		REG_PIVOT_Y = 3'd1,
		REG_PIVOT_Z = 3'd2,
		REG_ANGLE_X = 3'd3,
		REG_ANGLE_Y = 3'd4,
		REG_ANGLE_Z = 3'd5
	} reg_idx_t;

	localparam logic [AngleW-1:0] AngleFull = 15'd23040;
	localparam logic [AngleW-1:0] AngleQuarter = 15'd5760;
	localparam logic [AngleW-1:0] AngleHalf = 15'd11520;
	localparam logic [AngleW-1:0] Angle3Quarter = 15'd17280;
	localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

	function automatic logic signed [ZW-1:0] arctan(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 22'sd737280;
			5'd1: r = 22'sd435242;
			5'd2: r = 22'sd229970;
			5'd3: r = 22'sd116736;
			5'd4: r = 22'sd58595;
			5'd5: r = 22'sd29326;
			5'd6: r = 22'sd14667;
			5'd7: r = 22'sd7334;
			5'd8: r = 22'sd3667;
			5'd9: r = 22'sd1833;
			5'd10: r = 22'sd917;
			5'd11: r = 22'sd458;
			5'd12: r = 22'sd229;
			5'd13: r = 22'sd115;
			5'd14: r = 22'sd57;
			5'd15: r = 22'sd29;
			5'd16: r = 22'sd14;
			5'd17: r = 22'sd7;
			5'd18: r = 22'sd4;
			5'd19: r = 22'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

>>> rtl/eulr_trig.sv
// eulr_trig: iterative cordic that turns an angle write into sine and cosine
// one rotation step per cycle, one instance per axis; uses eulr_pkg
module eulr_trig #(
	parameter int TRIG_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [eulr_pkg::AngleW-1:0] angle,
	output logic wr_en,
	output logic busy,
	output logic signed [TRIG_WIDTH-1:0] sine,
	output logic signed [TRIG_WIDTH-1:0] cosine
);
	import eulr_pkg::*;
	localparam int F = TRIG_WIDTH - 1;
	localparam int Sh = 30 - F;
	localparam logic signed [CordicW-1:0] One = CordicW'((64'sd1 <<< F) - 1);

	logic busy_q, neg_q;
	logic [4:0] step_q;
	logic signed [CordicW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [AngleW-1:0] a;
	logic signed [AngleW:0] r;
	logic [2:0] quad;
	logic exact, rneg;

	function automatic logic signed [TRIG_WIDTH-1:0] rnd(input logic signed [CordicW-1:0] v,
			input logic n);
		logic signed [CordicW-1:0] t;
		t = (v + CordicW'(64'sd1 <<< (Sh - 1))) >>> Sh;
		if (t > One) t = One;
		if (t < -One) t = -One;
		if (n) t = -t;
		return t[TRIG_WIDTH-1:0];
	endfunction

	assign busy = busy_q | wr_en;

	always_comb begin
		a = (angle >= AngleFull) ? angle - AngleFull : angle;
		exact = 1'b1;
		quad = 3'd4;
		if (a == '0) quad = 3'd0;
		else if (a == AngleQuarter) quad = 3'd1;
		else if (a == AngleHalf) quad = 3'd2;
		else if (a == Angle3Quarter) quad = 3'd3;
		else exact = 1'b0;
		rneg = 1'b0;
		if (a < AngleQuarter) r = $signed({1'b0, a});
		else if (a < Angle3Quarter) begin
			r = $signed({1'b0, a}) - $signed({1'b0, AngleHalf});
			rneg = 1'b1;
		end else r = $signed({1'b0, a}) - $signed({1'b0, AngleFull});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wr_en <= 1'b0;
			step_q <= '0;
			neg_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			sine <= '0;
			cosine <= '0;
		end else begin
			wr_en <= 1'b0;
			if (start) begin
				if (exact) begin
					busy_q <= 1'b0;
					wr_en <= 1'b1;
					case (quad)
						3'd0: begin sine <= '0; cosine <= One[TRIG_WIDTH-1:0]; end
						3'd1: begin sine <= One[TRIG_WIDTH-1:0]; cosine <= '0; end
						3'd2: begin sine <= '0; cosine <= -One[TRIG_WIDTH-1:0]; end
						default: begin sine <= -One[TRIG_WIDTH-1:0]; cosine <= '0; end
					endcase
				end else begin
					busy_q <= 1'b1;
					step_q <= '0;
					neg_q <= rneg;
					x_q <= CordicGain;
					y_q <= '0;
					z_q <= ZW'(r) <<< 8;
				end
			end else if (busy_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - (y_q >>> step_q);
					y_q <= y_q + (x_q >>> step_q);
					z_q <= z_q - arctan(step_q);
				end else begin
					x_q <= x_q + (y_q >>> step_q);
					y_q <= y_q - (x_q >>> step_q);
					z_q <= z_q + arctan(step_q);
				end
				step_q <= step_q + 5'd1;
				if (step_q == 5'(CordicSteps)) begin
					busy_q <= 1'b0;
					wr_en <= 1'b1;
					sine <= rnd(y_q, neg_q);
					cosine <= rnd(x_q, neg_q);
				end
			end
		end
	end
endmodule

>>> rtl/eulr_stage.sv
// eulr_stage: one planar rotation about a pivot, two register stages
// multiplies then rounds, offsets and saturates; no package use
module eulr_stage #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_WIDTH = 16
) (
	input  logic clk,
	input  logic en,
	input  logic signed [COORD_WIDTH-1:0] a,
	input  logic signed [COORD_WIDTH-1:0] b,
	input  logic signed [COORD_WIDTH-1:0] c_in,
	input  logic flag_in,
	input  logic signed [COORD_WIDTH-1:0] pa,
	input  logic signed [COORD_WIDTH-1:0] pb,
	input  logic signed [TRIG_WIDTH-1:0] s,
	input  logic signed [TRIG_WIDTH-1:0] c,
	output logic signed [COORD_WIDTH-1:0] a_out,
	output logic signed [COORD_WIDTH-1:0] b_out,
	output logic signed [COORD_WIDTH-1:0] c_out,
	output logic flag_out
);
	localparam int F = TRIG_WIDTH - 1;
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = DW + TRIG_WIDTH;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] Half = SW'(64'sd1 <<< (F - 1));
	localparam logic signed [SW-1:0] Hi = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SW-1:0] Lo = -SW'(64'sd1 <<< (COORD_WIDTH - 1));

	logic signed [DW-1:0] da, db;
	logic signed [PW-1:0] ac_s1, bs_s1, as_s1, bc_s1;
	logic signed [COORD_WIDTH-1:0] pa_s1, pb_s1, c_s1;
	logic flag_s1;
	logic signed [SW-1:0] na, nb;

	assign da = DW'(a) - DW'(pa);
	assign db = DW'(b) - DW'(pb);

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1 <= da * c;
			bs_s1 <= db * s;
			as_s1 <= da * s;
			bc_s1 <= db * c;
			pa_s1 <= pa;
			pb_s1 <= pb;
			c_s1 <= c_in;
			flag_s1 <= flag_in;
		end
	end

	always_comb begin
		na = SW'(pa_s1) + ((SW'(ac_s1) - SW'(bs_s1) + Half) >>> F);
		nb = SW'(pb_s1) + ((SW'(as_s1) + SW'(bc_s1) + Half) >>> F);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_out <= (na > Hi) ? Hi[COORD_WIDTH-1:0] : (na < Lo) ? Lo[COORD_WIDTH-1:0] :
				na[COORD_WIDTH-1:0];
			b_out <= (nb > Hi) ? Hi[COORD_WIDTH-1:0] : (nb < Lo) ? Lo[COORD_WIDTH-1:0] :
				nb[COORD_WIDTH-1:0];
			c_out <= c_s1;
			flag_out <= flag_s1 | (na > Hi) | (na < Lo) | (nb > Hi) | (nb < Lo);
		end
	end
endmodule

>>> rtl/euler_xyz_rotate_about_pivot.sv
// euler_xyz_rotate_about_pivot: top level, config registers, six-stage pipeline
// uses eulr_pkg, three eulr_trig and three eulr_stage instances
//
// channel   signals                              role
// in        in_valid in_ready point_x/y/z        point beat in
// out       out_valid out_ready rotated_*, sat   rotated beat out
// cfg       cfg_we cfg_index cfg_data            register write
//
// one point a cycle unless stalled; per axis a multiply and a round+saturate stage
// whole pipeline advances together; a stalled output holds every stage
// an angle write holds in_ready low while its cordic runs and while its result is written
// reset clears valid bits, pivots to zero and trig to sine 0, cosine one
module euler_xyz_rotate_about_pivot #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COORD_WIDTH-1:0] rotated_x,
	output logic signed [COORD_WIDTH-1:0] rotated_y,
	output logic signed [COORD_WIDTH-1:0] rotated_z,
	output logic saturated,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	import eulr_pkg::*;

	logic signed [COORD_WIDTH-1:0] pvx_q, pvy_q, pvz_q;
	logic signed [TRIG_WIDTH-1:0] sin_q [3];
	logic signed [TRIG_WIDTH-1:0] cos_q [3];
	logic signed [TRIG_WIDTH-1:0] t_sin [3];
	logic signed [TRIG_WIDTH-1:0] t_cos [3];
	logic [2:0] t_we, t_busy, t_start;
	logic [5:0] vld_q;
	logic en, trig_busy;
	logic signed [COORD_WIDTH-1:0] y1, z1, x1, z2, x2, x3, y3, z3;
	logic f1, f2, f3;

	assign en = !vld_q[5] || out_ready;
	assign trig_busy = |t_busy;
	assign in_ready = en && !trig_busy;
	assign out_valid = vld_q[5];
	assign t_start[0] = cfg_we && cfg_index == REG_ANGLE_X;
	assign t_start[1] = cfg_we && cfg_index == REG_ANGLE_Y;
	assign t_start[2] = cfg_we && cfg_index == REG_ANGLE_Z;

	for (genvar g = 0; g < 3; g++) begin : g_trig
		eulr_trig #(.TRIG_WIDTH(TRIG_WIDTH)) u_trig (
			.clk(clk), .arst_n(arst_n), .start(t_start[g]),
			.angle(cfg_data[AngleW-1:0]), .wr_en(t_we[g]), .busy(t_busy[g]),
			.sine(t_sin[g]), .cosine(t_cos[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvx_q <= '0;
			pvy_q <= '0;
			pvz_q <= '0;
			vld_q <= '0;
			for (int i = 0; i < 3; i++) begin
				sin_q[i] <= '0;
				cos_q[i] <= TRIG_WIDTH'((64'sd1 <<< (TRIG_WIDTH - 1)) - 1);
			end
		end else begin
			if (en) vld_q <= {vld_q[4:0], in_valid && in_ready};
			if (cfg_we && cfg_index == REG_PIVOT_X) pvx_q <= cfg_data;
			if (cfg_we && cfg_index == REG_PIVOT_Y) pvy_q <= cfg_data;
			if (cfg_we && cfg_index == REG_PIVOT_Z) pvz_q <= cfg_data;
			for (int i = 0; i < 3; i++) begin
				if (t_we[i]) begin
					sin_q[i] <= t_sin[i];
					cos_q[i] <= t_cos[i];
				end
			end
		end
	end

	// about x: (y, z)
	eulr_stage #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_sx (
		.clk(clk), .en(en), .a(point_y), .b(point_z), .c_in(point_x), .flag_in(1'b0),
		.pa(pvy_q), .pb(pvz_q), .s(sin_q[0]), .c(cos_q[0]),
		.a_out(y1), .b_out(z1), .c_out(x1), .flag_out(f1)
	);
	// about y: (z, x)
	eulr_stage #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_sy (
		.clk(clk), .en(en), .a(z1), .b(x1), .c_in(y1), .flag_in(f1),
		.pa(pvz_q), .pb(pvx_q), .s(sin_q[1]), .c(cos_q[1]),
		.a_out(z2), .b_out(x2), .c_out(y3), .flag_out(f2)
	);
	// about z: (x, y)
	eulr_stage #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_sz (
		.clk(clk), .en(en), .a(x2), .b(y3), .c_in(z2), .flag_in(f2),
		.pa(pvx_q), .pb(pvy_q), .s(sin_q[2]), .c(cos_q[2]),
		.a_out(x3), .b_out(rotated_y), .c_out(z3), .flag_out(f3)
	);

	assign rotated_x = x3;
	assign rotated_z = z3;
	assign saturated = f3;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rotated_x) && $stable(saturated))
		else $error("output beat changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !trig_busy |-> in_ready) else $error("pipeline stalled with empty output");
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !trig_busy) else $error("point taken while trig pending");
endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for euler_xyz_rotate_about_pivot
// queue-fed driver and clocked monitor, with a cordic-based predictor held locally
// depends on eulr_pkg and the rtl top level only
`timescale 1ns / 1ps

module testbench;
	import eulr_pkg::*;

	localparam logic [2:0] RegSpareLo = 3'd6;
	localparam logic [2:0] RegSpareHi = 3'd7;
	localparam longint TrigOne = 32767;
	localparam longint CoordHi = 64'sd2147483647;
	localparam longint CoordLo = -64'sd2147483648;
	localparam int CycleLimit = 400000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic sat;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] rotated_x;
	logic signed [31:0] rotated_y;
	logic signed [31:0] rotated_z;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	point_t pending_points[$];
	rotated_t expected_rotations[$];
	longint pivot[3];
	longint sine_q[3];
	longint cosine_q[3];
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int recv_hold = 0;
	bit calm = 1'b0;
	bit took = 1'b0;

	euler_xyz_rotate_about_pivot uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
		.saturated(saturated),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint trig_round(longint v);
		longint r;
		r = (v + (64'sd1 <<< 14)) >>> 15;
		if (r > TrigOne) r = TrigOne;
		if (r < -TrigOne) r = -TrigOne;
		return r;
	endfunction

	function automatic void derive_trig(int axis, logic [31:0] raw);
		longint a, r, cx, cy, cz, nx;
		bit neg;
		neg = 1'b0;
		a = raw[14:0];
		if (a >= AngleFull) a -= AngleFull;
		if (a % AngleQuarter == 0) begin
			case (a / AngleQuarter)
				0: begin sine_q[axis] = 0; cosine_q[axis] = TrigOne; end
				1: begin sine_q[axis] = TrigOne; cosine_q[axis] = 0; end
				2: begin sine_q[axis] = 0; cosine_q[axis] = -TrigOne; end
				default: begin sine_q[axis] = -TrigOne; cosine_q[axis] = 0; end
			endcase
			return;
		end
		if (a < AngleQuarter) r = a;
		else if (a < Angle3Quarter) begin
			r = a - AngleHalf;
			neg = 1'b1;
		end else r = a - AngleFull;
		cz = r * 256;
		cx = CordicGain;
		cy = 0;
		for (int i = 0; i < CordicSteps; i++) begin
			if (cz >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				cz -= arctan(i[4:0]);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				cz += arctan(i[4:0]);
			end
			cx = nx;
		end
		cx = trig_round(cx);
		cy = trig_round(cy);
		sine_q[axis] = neg ? -cy : cy;
		cosine_q[axis] = neg ? -cx : cx;
	endfunction

	function automatic longint clip(longint v, inout bit f);
		if (v > CoordHi) begin f = 1'b1; return CoordHi; end
		if (v < CoordLo) begin f = 1'b1; return CoordLo; end
		return v;
	endfunction

	function automatic void turn_pair(inout longint a, inout longint b, input int axis,
			input longint pa, input longint pb, inout bit f);
		longint da, db, c, s, na, nb;
		c = cosine_q[axis];
		s = sine_q[axis];
		da = a - pa;
		db = b - pb;
		na = pa + ((da * c - db * s + (64'sd1 <<< 14)) >>> 15);
		nb = pb + ((da * s + db * c + (64'sd1 <<< 14)) >>> 15);
		a = clip(na, f);
		b = clip(nb, f);
	endfunction

	function automatic rotated_t rotate_point(point_t p);
		longint x, y, z;
		bit f;
		rotated_t r;
		x = p.x;
		y = p.y;
		z = p.z;
		f = 1'b0;
		turn_pair(y, z, 0, pivot[1], pivot[2], f);
		turn_pair(z, x, 1, pivot[2], pivot[0], f);
		turn_pair(x, y, 2, pivot[0], pivot[1], f);
		r.x = x[31:0];
		r.y = y[31:0];
		r.z = z[31:0];
		r.sat = f;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// drive on the falling edge so the register takes the value on a rising edge
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_PIVOT_X: pivot[0] = longint'(signed'(value));
			REG_PIVOT_Y: pivot[1] = longint'(signed'(value));
			REG_PIVOT_Z: pivot[2] = longint'(signed'(value));
			REG_ANGLE_X: derive_trig(0, value);
			REG_ANGLE_Y: derive_trig(1, value);
			REG_ANGLE_Z: derive_trig(2, value);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= $urandom;
	endtask

	task automatic settle();
		wait (pending_points.size() == 0 && !in_valid && expected_rotations.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_all(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
		settle();
		write_reg(REG_PIVOT_X, px);
		write_reg(REG_PIVOT_Y, py);
		write_reg(REG_PIVOT_Z, pz);
		write_reg(REG_ANGLE_X, ax);
		write_reg(REG_ANGLE_Y, ay);
		write_reg(REG_ANGLE_Z, az);
		// cordic runs after an angle write
		repeat (40) @(posedge clk);
	endtask

	task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		pending_points.push_back(p);
	endtask

	function automatic logic [31:0] any_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 65535)
				: 32'h8000_0000 + $urandom_range(0, 65535);
			default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h00ff_ffff)
				: -$urandom_range(0, 32'h00ff_ffff);
		endcase
	endfunction

	function automatic logic [31:0] any_angle();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3) * AngleQuarter;
			1: return $urandom_range(23040, 32767) | ($urandom & 32'hffff_8000);
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// input beats: predict at acceptance
	always @(posedge clk) begin
		took = in_valid && in_ready;
		if (took) expected_rotations.push_back(rotate_point('{point_x, point_y, point_z}));
	end

	// output beats
	always @(posedge clk) begin
		rotated_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rotations.size() == 0) begin
				report("unexpected beat", rotated_x, 0);
			end else begin
				want = expected_rotations.pop_front();
				if (rotated_x !== want.x) report("rotated_x", rotated_x, want.x);
				if (rotated_y !== want.y) report("rotated_y", rotated_y, want.y);
				if (rotated_z !== want.z) report("rotated_z", rotated_z, want.z);
				if (saturated !== want.sat) report("saturated", saturated, want.sat);
			end
		end
	end

	always @(negedge clk) begin
		point_t p;
		if (arst_n && !(in_valid && !took)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				p = pending_points.pop_front();
				point_x <= p.x;
				point_y <= p.y;
				point_z <= p.z;
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_hold > 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 6) == 0) recv_gap = $urandom_range(1, 13);
			end
		end
	end

	initial begin
		for (int i = 0; i < 3; i++) begin
			pivot[i] = 0;
			sine_q[i] = 0;
			cosine_q[i] = TrigOne;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// reset trig: identity
		push_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
		push_point(32'h0001_0000, 32'hffff_0000, 32'h1234_5678);
		// right angles
		set_all(32'h0, 32'h0, 32'h0, AngleQuarter, AngleHalf, Angle3Quarter);
		push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		push_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		// wrapped angles and the last step below full turn
		set_all(32'h0010_0000, 32'hfff0_0000, 32'h0, 32'd32767, 32'd23040, 32'd23039);
		push_point(32'h0001_8000, 32'hfffe_8000, 32'h0000_4000);
		push_point(32'hffff_ffff, 32'h0, 32'h1);
		// overflow through a far pivot
		set_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd2880, 32'd8640, 32'd1);
		push_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		push_point(32'h0, 32'h0, 32'h0);
		push_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
		// spare indexes are ignored
		settle();
		write_reg(RegSpareLo, 32'hffff_ffff);
		write_reg(RegSpareHi, 32'h5555_5555);
		repeat (40) @(posedge clk);
		push_point(32'h0003_0000, 32'h0004_0000, 32'h0005_0000);
		push_point(32'h8000_0001, 32'h0, 32'h7fff_fffe);

		for (int ph = 0; ph < 8; ph++) begin
			set_all(any_coord(), any_coord(), any_coord(), any_angle(), any_angle(),
				any_angle());
			if (ph == 7) calm = 1'b1;
			if (ph == 2) begin
				@(posedge clk);
				recv_hold = 300;
			end
			for (int n = 0; n < 200; n++) push_point(any_coord(), any_coord(), any_coord());
		end

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end
endmodule
